>>> src/hpm_pkg.sv
// ----------------------------------------------------------------------------
// hpm_pkg
// Shared types and constants for the homography point mapper.
// ----------------------------------------------------------------------------
package hpm_pkg;

  localparam int PIX_BITS  = 24;
  localparam int COEF_BITS = 32;
  localparam int CFG_DATA_BITS = 64;
  localparam int CFG_IDX_BITS  = 3;
  localparam int SIZE_BITS = 14;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_COEF_X   = 3'd0,
    REG_COEF_Y   = 3'd1,
    REG_COEF_W   = 3'd2,
    REG_OFF_XY   = 3'd3,
    REG_OFF_W    = 3'd4,
    REG_DEST_W   = 3'd5,
    REG_DEST_H   = 3'd6,
    REG_NONE     = 3'd7
  } hpm_reg_t;

  localparam logic [CFG_DATA_BITS-1:0] COEF_X_RST = 64'h0000_0000_7FFF_FFFF;
  localparam logic [CFG_DATA_BITS-1:0] COEF_Y_RST = 64'h7FFF_FFFF_0000_0000;
  localparam logic [COEF_BITS-1:0]     OFF_W_RST  = 32'h7FFF_FFFF;
  localparam logic [SIZE_BITS-1:0]     SIZE_RST   = 14'd8192;

  // Side information that rides along the divider stages
  typedef struct packed {
    logic                pos_x;  // x/w >= 0
    logic                pos_y;  // y/w >= 0
    logic [PIX_BITS-1:0] pix;
  } hpm_side_t;

endpackage

>>> src/hpm_if.sv
// ----------------------------------------------------------------------------
// hpm_in_if / hpm_out_if
// Valid/ready channels carrying source pixels in and mapped pixels out.
// ----------------------------------------------------------------------------
interface hpm_in_if #(parameter int SRC_BITS = 12) ();
  import hpm_pkg::*;
  logic                valid;
  logic                ready;
  logic [SRC_BITS-1:0] src_col;
  logic [SRC_BITS-1:0] src_row;
  logic [PIX_BITS-1:0] pixel_value;

  modport source(output valid, src_col, src_row, pixel_value, input ready);
  modport sink(input valid, src_col, src_row, pixel_value, output ready);
endinterface

interface hpm_out_if #(parameter int DEST_BITS = 13) ();
  import hpm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [DEST_BITS-1:0] dest_col;
  logic [DEST_BITS-1:0] dest_row;
  logic [PIX_BITS-1:0]  pixel_out;
  logic                 in_range;

  modport source(output valid, dest_col, dest_row, pixel_out, in_range, input ready);
  modport sink(input valid, dest_col, dest_row, pixel_out, in_range, output ready);
endinterface

>>> src/hpm_div_stage.sv
// ----------------------------------------------------------------------------
// hpm_div_stage
// One restoring-division step for both x/w and y/w: resolves one quotient bit.
// ----------------------------------------------------------------------------
module hpm_div_stage #(
  parameter int MW  = 45,  // magnitude width of numerator and divisor
  parameter int QW  = 14,  // quotient width
  parameter int BIT = 13   // quotient bit resolved here
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  vld_i,
  input  logic [MW-1:0]         rx_i,
  input  logic [MW-1:0]         ry_i,
  input  logic [MW-1:0]         ad_i,
  input  logic [QW-1:0]         qx_i,
  input  logic [QW-1:0]         qy_i,
  input  hpm_pkg::hpm_side_t    side_i,
  output logic                  vld_o,
  output logic [MW-1:0]         rx_o,
  output logic [MW-1:0]         ry_o,
  output logic [MW-1:0]         ad_o,
  output logic [QW-1:0]         qx_o,
  output logic [QW-1:0]         qy_o,
  output hpm_pkg::hpm_side_t    side_o
);
  import hpm_pkg::*;

  localparam int RW = MW + QW - 1;

  logic [RW-1:0] trial;
  logic          gex, gey;
  logic [MW-1:0] rx_nxt, ry_nxt;
  logic [QW-1:0] qx_nxt, qy_nxt;
  logic          vld_r;
  logic [MW-1:0] rx_r, ry_r, ad_r;
  logic [QW-1:0] qx_r, qy_r;
  hpm_side_t     side_r;

  // Compare remainder with shifted divisor, subtract when it fits
  always_comb begin
    trial  = RW'(ad_i) << BIT;
    gex    = RW'(rx_i) >= trial;
    gey    = RW'(ry_i) >= trial;
    rx_nxt = gex ? MW'(RW'(rx_i) - trial) : rx_i;
    ry_nxt = gey ? MW'(RW'(ry_i) - trial) : ry_i;
    qx_nxt = qx_i;
    qy_nxt = qy_i;
    qx_nxt[BIT] = gex;
    qy_nxt[BIT] = gey;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx_r   <= rx_nxt;
      ry_r   <= ry_nxt;
      ad_r   <= ad_i;
      qx_r   <= qx_nxt;
      qy_r   <= qy_nxt;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign rx_o   = rx_r;
  assign ry_o   = ry_r;
  assign ad_o   = ad_r;
  assign qx_o   = qx_r;
  assign qy_o   = qy_r;
  assign side_o = side_r;

endmodule

>>> src/homography_point_mapper.sv
// ----------------------------------------------------------------------------
// homography_point_mapper
// Forward projective warp of one source pixel per item.
// ----------------------------------------------------------------------------
// Usage:
//   in_pix carries (src_col, src_row, pixel_value); out_pix returns
//   (dest_col, dest_row, pixel_out, in_range), one result per item, in order.
//   The cfg port writes the homography coefficients and destination size;
//   write it only while the pipeline is empty.
// Stages, registered in order from accept to result valid: multiply,
//   sum, magnitude, DEST_COORD_BITS + 1 restoring-division steps (one
//   quotient bit per stage, x and y in parallel), output register.
// Throughput: one item per clock when not stalled; the division pipeline sets the depth.
// Stall: the whole pipeline holds while a result waits and out_pix.ready is
//   low; in_pix.ready then drops. Nothing is dropped or repeated.
// Reset: rst_n clears all valid bits and loads the identity homography and
//   an 8192 x 8192 destination.
// ----------------------------------------------------------------------------
module homography_point_mapper #(
  parameter int SRC_COORD_BITS  = 12,
  parameter int DEST_COORD_BITS = 13,
  parameter int COEF_FRAC_BITS  = 31
) (
  input  logic                               clk,
  input  logic                               rst_n,
  hpm_in_if.sink                             in_pix,
  hpm_out_if.source                          out_pix,
  input  logic                               cfg_we,
  input  logic [hpm_pkg::CFG_IDX_BITS-1:0]   cfg_idx,
  input  logic [hpm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import hpm_pkg::*;

  localparam int S   = SRC_COORD_BITS;
  localparam int D   = DEST_COORD_BITS;
  localparam int PW  = COEF_BITS + S + 1;  // product width
  localparam int NW  = PW + 1;             // sum width, signed
  localparam int MW  = NW - 1;             // magnitude width
  localparam int QW  = D + 1;              // quotient incl. overflow bit
  localparam int CW  = ((D > SIZE_BITS) ? D : SIZE_BITS) + 1;
  localparam logic signed [NW-1:0] W_ONE =
    {{(NW-COEF_FRAC_BITS-1){1'b0}}, 1'b1, {COEF_FRAC_BITS{1'b0}}};

  // Configuration registers
  logic [CFG_DATA_BITS-1:0] coef_x_r, coef_y_r, coef_w_r, off_xy_r;
  logic [COEF_BITS-1:0]     off_w_r;
  logic [SIZE_BITS-1:0]     dest_w_r, dest_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_x_r <= COEF_X_RST;
      coef_y_r <= COEF_Y_RST;
      coef_w_r <= '0;
      off_xy_r <= '0;
      off_w_r  <= OFF_W_RST;
      dest_w_r <= SIZE_RST;
      dest_h_r <= SIZE_RST;
    end else if (cfg_we) begin
      case (hpm_reg_t'(cfg_idx))
        REG_COEF_X: coef_x_r <= cfg_data;
        REG_COEF_Y: coef_y_r <= cfg_data;
        REG_COEF_W: coef_w_r <= cfg_data;
        REG_OFF_XY: off_xy_r <= cfg_data;
        REG_OFF_W:  off_w_r  <= cfg_data[COEF_BITS-1:0];
        REG_DEST_W: dest_w_r <= cfg_data[SIZE_BITS-1:0];
        REG_DEST_H: dest_h_r <= cfg_data[SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_vld_r;
  assign en           = !out_vld_r || out_pix.ready;
  assign in_pix.ready = en;

  // Stage 1: six products
  logic signed [S:0]         col_s, row_s;
  logic signed [PW-1:0]      p11_r, p12_r, p21_r, p22_r, p31_r, p32_r;
  logic signed [PW-1:0]      p11_nxt, p12_nxt, p21_nxt, p22_nxt, p31_nxt, p32_nxt;
  logic                      s1_vld_r;
  logic [PIX_BITS-1:0]       s1_pix_r;

  always_comb begin
    col_s   = signed'({1'b0, in_pix.src_col});
    row_s   = signed'({1'b0, in_pix.src_row});
    p11_nxt = PW'(signed'(coef_x_r[31:0]))  * PW'(col_s);
    p12_nxt = PW'(signed'(coef_x_r[63:32])) * PW'(row_s);
    p21_nxt = PW'(signed'(coef_y_r[31:0]))  * PW'(col_s);
    p22_nxt = PW'(signed'(coef_y_r[63:32])) * PW'(row_s);
    p31_nxt = PW'(signed'(coef_w_r[31:0]))  * PW'(col_s);
    p32_nxt = PW'(signed'(coef_w_r[63:32])) * PW'(row_s);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p11_r    <= p11_nxt;
      p12_r    <= p12_nxt;
      p21_r    <= p21_nxt;
      p22_r    <= p22_nxt;
      p31_r    <= p31_nxt;
      p32_r    <= p32_nxt;
      s1_pix_r <= in_pix.pixel_value;
    end
  end

  // Stage 2: dot products with offsets, w of zero becomes one
  logic signed [NW-1:0] x_nxt, y_nxt, w_sum, w_nxt;
  logic signed [NW-1:0] x_r, y_r, w_r;
  logic                 s2_vld_r;
  logic [PIX_BITS-1:0]  s2_pix_r;

  always_comb begin
    x_nxt = NW'(p11_r) + NW'(p12_r) + NW'(signed'(off_xy_r[31:0]));
    y_nxt = NW'(p21_r) + NW'(p22_r) + NW'(signed'(off_xy_r[63:32]));
    w_sum = NW'(p31_r) + NW'(p32_r) + NW'(signed'(off_w_r));
    w_nxt = (w_sum == '0) ? W_ONE : w_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      w_r      <= w_nxt;
      s2_pix_r <= s1_pix_r;
    end
  end

  // Stage 3: magnitudes and quotient signs
  logic [MW-1:0] ax_nxt, ay_nxt, aw_nxt;
  logic [MW-1:0] ax_r, ay_r, aw_r;
  logic          nx, ny, nw;
  logic          s3_vld_r;
  hpm_side_t     s3_side_nxt, s3_side_r;

  always_comb begin
    nx     = x_r[NW-1];
    ny     = y_r[NW-1];
    nw     = w_r[NW-1];
    ax_nxt = nx ? MW'(-x_r) : MW'(x_r);
    ay_nxt = ny ? MW'(-y_r) : MW'(y_r);
    aw_nxt = nw ? MW'(-w_r) : MW'(w_r);
    s3_side_nxt.pos_x = (x_r == '0) || (nx == nw);
    s3_side_nxt.pos_y = (y_r == '0) || (ny == nw);
    s3_side_nxt.pix   = s2_pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r      <= ax_nxt;
      ay_r      <= ay_nxt;
      aw_r      <= aw_nxt;
      s3_side_r <= s3_side_nxt;
    end
  end

  // Division pipeline, most significant quotient bit first
  logic          dv_vld  [QW+1];
  logic [MW-1:0] dv_rx   [QW+1];
  logic [MW-1:0] dv_ry   [QW+1];
  logic [MW-1:0] dv_ad   [QW+1];
  logic [QW-1:0] dv_qx   [QW+1];
  logic [QW-1:0] dv_qy   [QW+1];
  hpm_side_t     dv_side [QW+1];

  assign dv_vld[0]  = s3_vld_r;
  assign dv_rx[0]   = ax_r;
  assign dv_ry[0]   = ay_r;
  assign dv_ad[0]   = aw_r;
  assign dv_qx[0]   = '0;
  assign dv_qy[0]   = '0;
  assign dv_side[0] = s3_side_r;

  for (genvar k = 0; k < QW; k++) begin : g_div
    hpm_div_stage #(.MW(MW), .QW(QW), .BIT(QW - 1 - k)) u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (dv_vld[k]),
      .rx_i   (dv_rx[k]),
      .ry_i   (dv_ry[k]),
      .ad_i   (dv_ad[k]),
      .qx_i   (dv_qx[k]),
      .qy_i   (dv_qy[k]),
      .side_i (dv_side[k]),
      .vld_o  (dv_vld[k+1]),
      .rx_o   (dv_rx[k+1]),
      .ry_o   (dv_ry[k+1]),
      .ad_o   (dv_ad[k+1]),
      .qx_o   (dv_qx[k+1]),
      .qy_o   (dv_qy[k+1]),
      .side_o (dv_side[k+1])
    );
  end

  // Output register: range test and zeroing
  logic [QW-1:0]       qx_f, qy_f;
  hpm_side_t           side_f;
  logic                ok;
  logic [D-1:0]        dcol_r, drow_r;
  logic [PIX_BITS-1:0] pix_r;
  logic                rng_r;

  always_comb begin
    qx_f   = dv_qx[QW];
    qy_f   = dv_qy[QW];
    side_f = dv_side[QW];
    ok = side_f.pos_x && side_f.pos_y && !qx_f[D] && !qy_f[D]
      && (CW'(qx_f[D-1:0]) < CW'(dest_w_r))
      && (CW'(qy_f[D-1:0]) < CW'(dest_h_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dcol_r <= ok ? qx_f[D-1:0] : '0;
      drow_r <= ok ? qy_f[D-1:0] : '0;
      pix_r  <= side_f.pix;
      rng_r  <= ok;
    end
  end

  assign out_pix.valid     = out_vld_r;
  assign out_pix.dest_col  = dcol_r;
  assign out_pix.dest_row  = drow_r;
  assign out_pix.pixel_out = pix_r;
  assign out_pix.in_range  = rng_r;

endmodule

>>> src/hpm_checker.sv
// ----------------------------------------------------------------------------
// hpm_checker
// Port-level checks for the homography point mapper, bound to the top level.
// ----------------------------------------------------------------------------
module hpm_checker #(
  parameter int DEST_BITS = 13
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [DEST_BITS-1:0] dest_col,
  input logic [DEST_BITS-1:0] dest_row,
  input logic                 in_range
);

  // A result held back keeps its valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out valid dropped while stalled");

  // Out-of-range results carry zero coordinates
  a_zero_oor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !in_range |-> (dest_col == '0) && (dest_row == '0))
    else $error("out-of-range item has nonzero coordinates");

  // Nothing comes out right after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // An empty output never blocks the input
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // A stalled output blocks the input
  a_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output stalled");

endmodule

bind homography_point_mapper hpm_checker #(.DEST_BITS(DEST_COORD_BITS)) u_hpm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_pix.ready),
  .out_valid (out_pix.valid),
  .out_ready (out_pix.ready),
  .dest_col  (out_pix.dest_col),
  .dest_row  (out_pix.dest_row),
  .in_range  (out_pix.in_range)
);

>>> tb/tb_homography_point_mapper.sv
// ----------------------------------------------------------------------------
// tb_homography_point_mapper
// Self-checking bench for the homography point mapper: a driver feeds source
// pixels from a queue, a monitor compares every mapped pixel against a
// behavioral mapping computed at acceptance time, across several homographies.
// ----------------------------------------------------------------------------
module tb_homography_point_mapper;
  import hpm_pkg::*;

  localparam int SRC_BITS  = 12;
  localparam int DEST_BITS = 13;
  localparam int FRAC_BITS = 31;
  localparam int LATENCY   = DEST_BITS + 5;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [SRC_BITS-1:0] col;
    logic [SRC_BITS-1:0] row;
    logic [PIX_BITS-1:0] pix;
  } src_pixel_t;

  typedef struct packed {
    logic [DEST_BITS-1:0] col;
    logic [DEST_BITS-1:0] row;
    logic [PIX_BITS-1:0]  pix;
    logic                 hit;
  } mapped_pixel_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_idx;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic in_fire;

  hpm_in_if  #(.SRC_BITS(SRC_BITS))   in_pix ();
  hpm_out_if #(.DEST_BITS(DEST_BITS)) out_pix ();

  homography_point_mapper #(
    .SRC_COORD_BITS(SRC_BITS), .DEST_COORD_BITS(DEST_BITS), .COEF_FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk(clk), .rst_n(rst_n), .in_pix(in_pix.sink), .out_pix(out_pix.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  // Shadow copy of the coefficient and size registers
  logic [63:0] hom_regs [0:6];

  src_pixel_t    pixel_queue[$];
  mapped_pixel_t mapped_expect[$];
  int   send_idle_pct, recv_idle_pct;
  int   errors, accepted, checked;
  longint cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint coef(input logic [63:0] r, input bit hi);
    logic [31:0] c;
    c = hi ? r[63:32] : r[31:0];
    return longint'($signed(c));
  endfunction

  // Map one source pixel through the current homography
  function automatic mapped_pixel_t map_pixel(input src_pixel_t s);
    mapped_pixel_t m;
    longint col, row, x, y, w, ax, ay, aw, qx, qy, wb, hb;
    bit px, py, ok;
    col = longint'(s.col);
    row = longint'(s.row);
    x = coef(hom_regs[0], 0) * col + coef(hom_regs[0], 1) * row + coef(hom_regs[3], 0);
    y = coef(hom_regs[1], 0) * col + coef(hom_regs[1], 1) * row + coef(hom_regs[3], 1);
    w = coef(hom_regs[2], 0) * col + coef(hom_regs[2], 1) * row + coef(hom_regs[4], 0);
    if (w == 0) w = longint'(1) << FRAC_BITS;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    aw = (w < 0) ? -w : w;
    qx = ax / aw;
    qy = ay / aw;
    px = (x == 0) || ((x < 0) == (w < 0));
    py = (y == 0) || ((y < 0) == (w < 0));
    wb = (hom_regs[5] > (1 << DEST_BITS)) ? (1 << DEST_BITS) : longint'(hom_regs[5]);
    hb = (hom_regs[6] > (1 << DEST_BITS)) ? (1 << DEST_BITS) : longint'(hom_regs[6]);
    ok = px && py && (qx < wb) && (qy < hb);
    m.col = ok ? qx[DEST_BITS-1:0] : '0;
    m.row = ok ? qy[DEST_BITS-1:0] : '0;
    m.pix = s.pix;
    m.hit = ok;
    return m;
  endfunction

  // Remember whether the presented item went in at the last rising edge
  always @(posedge clk) begin
    in_fire <= in_pix.valid && in_pix.ready;
  end

  // Driver: present queued items at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_pix.valid <= 1'b0;
    end else if (in_pix.valid && !in_fire) begin
      // hold the item
    end else if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      in_pix.valid       <= 1'b1;
      in_pix.src_col     <= pixel_queue[0].col;
      in_pix.src_row     <= pixel_queue[0].row;
      in_pix.pixel_value <= pixel_queue[0].pix;
      void'(pixel_queue.pop_front());
    end else begin
      in_pix.valid <= 1'b0;
    end
    out_pix.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: record accepted items, check accepted results
  always @(posedge clk) begin
    mapped_pixel_t got, want;
    if (rst_n) begin
      cycles <= cycles + 1;
      if (in_pix.valid && in_pix.ready) begin
        mapped_expect.insert(mapped_expect.size(),
                             map_pixel({in_pix.src_col, in_pix.src_row,
                                        in_pix.pixel_value}));
        accepted <= accepted + 1;
      end
      if (out_pix.valid && out_pix.ready) begin
        got = {out_pix.dest_col, out_pix.dest_row, out_pix.pixel_out, out_pix.in_range};
        checked <= checked + 1;
        if (mapped_expect.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors <= errors + 1;
        end else begin
          want = mapped_expect.pop_front();
          if (got.col !== want.col || got.row !== want.row ||
              got.pix !== want.pix || got.hit !== want.hit) begin
            $display("%0t: mismatch exp col=%0d row=%0d pix=%h hit=%b",
                     $time, want.col, want.row, want.pix, want.hit,
                     " got col=%0d row=%0d pix=%h hit=%b",
                     got.col, got.row, got.pix, got.hit);
            errors <= errors + 1;
          end
        end
      end
    end
  end

  // Timeout guard
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(input hpm_reg_t idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx != REG_NONE) begin
      if (idx == REG_OFF_W) hom_regs[idx] = {32'd0, val[31:0]};
      else if (idx == REG_DEST_W || idx == REG_DEST_H) hom_regs[idx] = {50'd0, val[13:0]};
      else hom_regs[idx] = val;
    end
  endtask

  // Wait until the pipeline has drained
  task automatic drain_pipeline();
    while (pixel_queue.size() > 0 || in_pix.valid || mapped_expect.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coef(input int span);
    // small-magnitude coefficient of span bits, random sign
    logic [31:0] v;
    v = $urandom() >> (32 - span);
    return $urandom_range(1) ? -v : v;
  endfunction

  task automatic queue_pixel(input int col, input int row, input int pix);
    src_pixel_t s;
    s.col = SRC_BITS'(col);
    s.row = SRC_BITS'(row);
    s.pix = PIX_BITS'(pix);
    pixel_queue.insert(pixel_queue.size(), s);
  endtask

  task automatic queue_random(input int n);
    repeat (n) queue_pixel($urandom_range(4095), $urandom_range(4095), $urandom());
  endtask

  // Random projective map with w kept mostly near one
  task automatic random_homography();
    write_reg(REG_COEF_X, {rand_coef(24), rand_coef(31)});
    write_reg(REG_COEF_Y, {rand_coef(31), rand_coef(24)});
    write_reg(REG_COEF_W, {rand_coef($urandom_range(8, 22)), rand_coef($urandom_range(8, 22))});
    write_reg(REG_OFF_XY, {rand_coef(31), rand_coef(31)});
    write_reg(REG_OFF_W, 64'(($urandom_range(3) == 0) ? rand_coef(31) : 32'h7FFF_FFFF));
    write_reg(REG_DEST_W,
              64'($urandom_range(3) == 0 ? $urandom_range(16383) : $urandom_range(1, 8192)));
    write_reg(REG_DEST_H,
              64'($urandom_range(3) == 0 ? $urandom_range(16383) : $urandom_range(1, 8192)));
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
    in_pix.valid = 1'b0; in_pix.src_col = '0; in_pix.src_row = '0;
    in_pix.pixel_value = '0; out_pix.ready = 1'b0;
    errors = 0; accepted = 0; checked = 0; cycles = 0;
    send_idle_pct = 18; recv_idle_pct = 84;
    hom_regs[0] = COEF_X_RST; hom_regs[1] = COEF_Y_RST; hom_regs[2] = '0;
    hom_regs[3] = '0; hom_regs[4] = {32'd0, OFF_W_RST};
    hom_regs[5] = 64'(SIZE_RST); hom_regs[6] = 64'(SIZE_RST);
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: identity at reset, field extremes
    queue_pixel(0, 0, 0);
    queue_pixel(4095, 4095, 24'hFFFFFF);
    queue_pixel(4095, 0, 24'h123456);
    queue_pixel(0, 4095, 24'hA5A5A5);
    queue_pixel(1, 1, 24'h5A5A5A);
    drain_pipeline();

    // Zero w becomes one; small bounds, zero size, oversize bound
    write_reg(REG_OFF_W, 64'd0);
    write_reg(REG_DEST_W, 64'd0);
    write_reg(REG_DEST_H, 64'd16383);
    queue_pixel(5, 7, 24'h010203);
    drain_pipeline();
    write_reg(REG_DEST_W, 64'd1);
    write_reg(REG_DEST_H, 64'd8191);
    queue_pixel(0, 8, 24'h0);
    queue_pixel(1, 8, 24'h0);
    drain_pipeline();

    // Negative x, tiny negative quotient, negative w, extreme coefficients
    write_reg(REG_COEF_X, 64'h0000_0000_8000_0000);
    write_reg(REG_COEF_Y, 64'h7FFF_FFFF_0000_0000);
    write_reg(REG_OFF_XY, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_OFF_W, 64'h0000_0000_8000_0000);
    write_reg(REG_DEST_W, 64'd8192);
    write_reg(REG_DEST_H, 64'd8192);
    write_reg(REG_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_pixel(0, 0, 24'h111111);
    queue_pixel(3, 0, 24'h222222);
    queue_pixel(0, 3, 24'h333333);
    queue_pixel(4095, 4095, 24'h444444);
    drain_pipeline();
    write_reg(REG_COEF_W, 64'h7FFF_FFFF_8000_0000);
    write_reg(REG_OFF_XY, 64'h7FFF_FFFF_8000_0000);
    write_reg(REG_OFF_W, 64'd1);
    queue_pixel(1, 0, 24'h555555);
    queue_pixel(0, 1, 24'h666666);
    queue_pixel(2048, 2048, 24'h777777);
    queue_random(5);
    drain_pipeline();

    // Random phases under three idling profiles
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin send_idle_pct = 84; recv_idle_pct = 18; end
      if (ph == 8) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      random_homography();
      queue_random(80);
      // pause the sender until all results are in, then continue
      drain_pipeline();
      queue_random(78);
      drain_pipeline();
    end

    $display("Covered %0d items, %0d results checked over 12 random homographies plus",
             accepted, checked);
    $display("directed zero-w, negative-quotient, size-bound and extreme-coefficient cases.");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> homography_point_mapper.f
src/hpm_pkg.sv
src/hpm_if.sv
src/hpm_div_stage.sv
src/homography_point_mapper.sv
src/hpm_checker.sv
tb/tb_homography_point_mapper.sv
